FILE: hdl/kscl_pkg.sv
// ----------------------------------------------------------------------------
// kscl_pkg
// Shared types, key codes and the keypad key table for the keypad scan code
// lock unit.
// ----------------------------------------------------------------------------
package kscl_pkg;

    // Key codes
    localparam logic [3:0] KEY_STAR   = 4'd10;
    localparam logic [3:0] SLOT_EMPTY = 4'd10;

    // Scanner phases
    localparam logic [2:0] PH_C0   = 3'd0;
    localparam logic [2:0] PH_C1   = 3'd1;
    localparam logic [2:0] PH_C2   = 3'd2;
    localparam logic [2:0] PH_READ = 3'd3;
    localparam logic [2:0] PH_WAIT = 3'd4;

    // Lock phases
    localparam logic [1:0] LK_INIT   = 2'd0;
    localparam logic [1:0] LK_LOCKED = 2'd1;
    localparam logic [1:0] LK_ENTRY  = 2'd2;
    localparam logic [1:0] LK_OPEN   = 2'd3;

    // Column pin patterns (active low)
    localparam logic [2:0] COL_ALL_HIGH = 3'b111;
    localparam logic [2:0] COL_DRIVE0   = 3'b110;
    localparam logic [2:0] COL_DRIVE1   = 3'b101;
    localparam logic [2:0] COL_DRIVE2   = 3'b011;

    // Configuration register indexes
    localparam logic CFG_FIRST_KEY  = 1'b0;
    localparam logic CFG_SECOND_KEY = 1'b1;

    localparam logic [3:0] CFG_FIRST_RESET  = 4'd1;
    localparam logic [3:0] CFG_SECOND_RESET = 4'd2;

    typedef struct packed {
        logic [3:0] first_key;
        logic [3:0] second_key;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [3:0] code;
    } t_key;

    typedef struct packed {
        logic       locked;
        logic       entry_enabled;
        logic [3:0] first_slot;
        logic [3:0] second_slot;
    } t_lock_status;

    // Keypad layout: row 0 = 1 2 3, row 1 = 4 5 6, row 2 = 7 8 9,
    // row 3 = star 0 hash
    function automatic logic [3:0] key_lookup(input logic [1:0] row,
                                              input logic [1:0] col);
        logic [3:0] k;
        k = 4'd0;
        case ({row, col})
            4'b00_00: k = 4'd1;
            4'b00_01: k = 4'd2;
            4'b00_10: k = 4'd3;
            4'b01_00: k = 4'd4;
            4'b01_01: k = 4'd5;
            4'b01_10: k = 4'd6;
            4'b10_00: k = 4'd7;
            4'b10_01: k = 4'd8;
            4'b10_10: k = 4'd9;
            4'b11_00: k = 4'd10;
            4'b11_01: k = 4'd0;
            4'b11_10: k = 4'd11;
            default:  k = 4'd0;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/kscl_in_if.sv
// ----------------------------------------------------------------------------
// kscl_in_if
// Scan tick channel: valid/ready handshake carrying the sampled row lines.
// ----------------------------------------------------------------------------
interface kscl_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_lines;

    modport source (output valid, output row_lines, input ready);
    modport sink   (input valid, input row_lines, output ready);
endinterface

FILE: hdl/kscl_out_if.sv
// ----------------------------------------------------------------------------
// kscl_out_if
// Result channel: valid/ready handshake carrying one result per scan tick.
// ----------------------------------------------------------------------------
interface kscl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] column_drive;
    logic       key_valid;
    logic [3:0] key_code;
    logic [3:0] first_slot;
    logic [3:0] second_slot;
    logic       locked;
    logic       entry_enabled;

    modport source (output valid, output column_drive, output key_valid,
                    output key_code, output first_slot, output second_slot,
                    output locked, output entry_enabled, input ready);
    modport sink   (input valid, input column_drive, input key_valid,
                    input key_code, input first_slot, input second_slot,
                    input locked, input entry_enabled, output ready);
endinterface

FILE: hdl/kscl_scan.sv
// ----------------------------------------------------------------------------
// kscl_scan
// Keypad column scanner: drives columns, latches the pressed column, reads
// the row in the same scan tick and waits for release.
// ----------------------------------------------------------------------------
module kscl_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [3:0]      i_row_lines,
    input  logic            i_access,
    output kscl_pkg::t_key  o_key,
    output logic [2:0]      o_pins
);
    import kscl_pkg::*;

    logic [2:0] r_phase, n_phase;
    logic [1:0] r_held, n_held;
    logic [2:0] r_pins, n_pins;
    logic       pressed;
    logic [1:0] row_sel;

    assign pressed = (i_row_lines != 4'hF);

    // Lowest low row wins
    always_comb begin
        if (!i_row_lines[0]) begin
            row_sel = 2'd0;
        end else if (!i_row_lines[1]) begin
            row_sel = 2'd1;
        end else if (!i_row_lines[2]) begin
            row_sel = 2'd2;
        end else begin
            row_sel = 2'd3;
        end
    end

    // Phase step, then pins and key for the new phase
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_pins  = r_pins;
        o_key   = '0;
        if (i_access) begin
            case (r_phase)
                PH_C0, PH_C1, PH_C2: begin
                    if (pressed) begin
                        n_held  = r_phase[1:0];
                        n_phase = PH_READ;
                    end else begin
                        n_phase = (r_phase == PH_C2) ? PH_C0 : r_phase + 3'd1;
                    end
                end
                PH_READ: begin
                    n_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    if (!pressed) begin
                        if (r_held == 2'd0) begin
                            n_phase = PH_C1;
                        end else if (r_held == 2'd1) begin
                            n_phase = PH_C2;
                        end else begin
                            n_phase = PH_C0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_C0;
                end
            endcase

            case (n_phase)
                PH_C0:   n_pins = COL_DRIVE0;
                PH_C1:   n_pins = COL_DRIVE1;
                PH_C2:   n_pins = COL_DRIVE2;
                PH_READ: begin
                    if (pressed && n_held != 2'd3) begin
                        o_key.valid = 1'b1;
                        o_key.code  = key_lookup(row_sel, n_held);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_pins = n_pins;

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_C0;
            r_held  <= 2'd0;
            r_pins  <= COL_ALL_HIGH;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_pins  <= n_pins;
        end
    end

endmodule

FILE: hdl/kscl_lock.sv
// ----------------------------------------------------------------------------
// kscl_lock
// Lock sequencer and two-slot code entry.
// ----------------------------------------------------------------------------
module kscl_lock (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  kscl_pkg::t_cfg         i_cfg,
    input  kscl_pkg::t_key         i_key,
    output logic                   o_access,
    output kscl_pkg::t_lock_status o_status
);
    import kscl_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic       r_lock, n_lock;
    logic       r_access, n_access;
    logic [3:0] r_slot0, n_slot0;
    logic [3:0] r_slot1, n_slot1;
    logic       clr;
    logic [3:0] s0_clr, s1_clr;

    // Lock phase step, compared against slots before this tick's key
    always_comb begin
        case (r_phase)
            LK_INIT:   n_phase = LK_LOCKED;
            LK_LOCKED: n_phase = LK_ENTRY;
            LK_ENTRY:  n_phase = (r_slot0 == i_cfg.first_key &&
                                  r_slot1 == i_cfg.second_key) ? LK_OPEN : LK_ENTRY;
            default:   n_phase = r_phase;
        endcase
        n_lock   = r_lock;
        n_access = r_access;
        case (n_phase)
            LK_LOCKED: begin
                n_lock   = 1'b1;
                n_access = 1'b0;
            end
            LK_ENTRY: n_access = 1'b1;
            LK_OPEN:  n_lock   = 1'b0;
            default: ;
        endcase
    end

    assign o_access = n_access;

    // Slot fill: star or a full entry clears first
    always_comb begin
        clr     = (i_key.code == KEY_STAR) || (r_slot1 != SLOT_EMPTY);
        s0_clr  = clr ? SLOT_EMPTY : r_slot0;
        s1_clr  = clr ? SLOT_EMPTY : r_slot1;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_key.valid) begin
            n_slot0 = s0_clr;
            n_slot1 = s1_clr;
            if (s0_clr == SLOT_EMPTY) begin
                n_slot0 = i_key.code;
            end else if (s1_clr == SLOT_EMPTY) begin
                n_slot1 = i_key.code;
            end
        end
    end

    assign o_status.locked        = n_lock;
    assign o_status.entry_enabled = n_access;
    assign o_status.first_slot    = n_slot0;
    assign o_status.second_slot   = n_slot1;

    // Lock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= LK_INIT;
            r_lock   <= 1'b0;
            r_access <= 1'b0;
            r_slot0  <= SLOT_EMPTY;
            r_slot1  <= SLOT_EMPTY;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_lock   <= n_lock;
            r_access <= n_access;
            r_slot0  <= n_slot0;
            r_slot1  <= n_slot1;
        end
    end

endmodule

FILE: hdl/keypad_scan_code_lock_unit.sv
// ----------------------------------------------------------------------------
// keypad_scan_code_lock_unit
// 4x3 keypad scanner feeding a two-key code lock, one result per scan tick.
// ----------------------------------------------------------------------------
// A result is registered and presented in the cycle after its scan tick is accepted.
// Throughput: one scan tick per cycle unless stalled; state and result register load together.
// A new transaction enters in the cycle the previous result is taken; while a
// result is stalled on the output the input is held off.
// Reset: synchronous active low; lock in init, slots empty, pins all high,
// code registers back to 1 and 2.
module keypad_scan_code_lock_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kscl_in_if.sink     i_in,
    kscl_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import kscl_pkg::*;

    t_cfg         r_cfg;
    t_key         key;
    t_lock_status status;
    logic         access;
    logic [2:0]   pins;
    logic         accept;
    logic         r_out_valid;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_key  <= CFG_FIRST_RESET;
            r_cfg.second_key <= CFG_SECOND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_KEY:  r_cfg.first_key  <= i_cfg_data;
                CFG_SECOND_KEY: r_cfg.second_key <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kscl_lock u_lock (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg    (r_cfg),
        .i_key    (key),
        .o_access (access),
        .o_status (status)
    );

    kscl_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_row_lines (i_in.row_lines),
        .i_access    (access),
        .o_key       (key),
        .o_pins      (pins)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_out.column_drive  <= pins;
            o_out.key_valid     <= key.valid;
            o_out.key_code      <= key.valid ? key.code : 4'd0;
            o_out.first_slot    <= status.first_slot;
            o_out.second_slot   <= status.second_slot;
            o_out.locked        <= status.locked;
            o_out.entry_enabled <= status.entry_enabled;
        end
    end

    assign o_out.valid = r_out_valid;

`ifndef SYNTHESIS
    // Every accepted transaction yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("result missing after accepted transaction");

    // Keys are only recorded while entry is enabled
    a_key_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.key_valid) |-> o_out.entry_enabled)
        else $error("key recorded with entry disabled");

    // At most one column is driven low
    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($onehot(~o_out.column_drive) ||
                         o_out.column_drive == COL_ALL_HIGH))
        else $error("more than one column driven");
`endif

endmodule
